// ===== design/tmwp_pkg.sv =====
package tmwp_pkg;

    // Sample width and window lengths.
    localparam int MS_W      = 24;
    localparam int SHORT_LEN = 5;
    localparam int LONG_LEN  = 12;
    localparam int TRIM      = 2;
    localparam int WIN_DEPTH = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    // The window taps are reduced in groups of GRP; the group results are registered.
    localparam int GRP       = 4;
    localparam int GRP_SUM_W = MS_W + $clog2(GRP);
    localparam int NGRP      = (WIN_DEPTH + GRP - 1) / GRP;
    localparam int TAP_N     = NGRP * GRP;
    localparam int FSUM_W    = MS_W + $clog2(TAP_N);

    // Trimmed sums and their divisors.
    localparam int SHORT_DIV  = SHORT_LEN - TRIM;
    localparam int LONG_DIV   = LONG_LEN - TRIM;
    localparam int SHORT_TS_W = MS_W + $clog2(SHORT_DIV);
    localparam int LONG_TS_W  = MS_W + $clog2(LONG_DIV);

    // Exact floor division by a constant: q = (x * MUL) >> K for every x below 2**TS_W.
    localparam int SHORT_K      = SHORT_TS_W + $clog2(SHORT_DIV);
    localparam int LONG_K       = LONG_TS_W + $clog2(LONG_DIV);
    localparam int SHORT_MUL_W  = SHORT_TS_W + 1;
    localparam int LONG_MUL_W   = LONG_TS_W + 1;
    localparam int SHORT_PROD_W = SHORT_TS_W + SHORT_MUL_W;
    localparam int LONG_PROD_W  = LONG_TS_W + LONG_MUL_W;
    localparam logic [SHORT_MUL_W-1:0] SHORT_MUL =
        SHORT_MUL_W'((64'd1 << SHORT_K) / 64'(SHORT_DIV) + 64'd1);
    localparam logic [LONG_MUL_W-1:0] LONG_MUL =
        LONG_MUL_W'((64'd1 << LONG_K) / 64'(LONG_DIV) + 64'd1);

    // Queue between the front and back parts.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int CREDIT_W = $clog2(QDEPTH + 1);

    typedef logic [MS_W-1:0] ms_t;

    typedef struct packed {
        ms_t                  lo;
        ms_t                  hi;
        logic [GRP_SUM_W-1:0] sum;
    } grp_stat_t;

    typedef struct packed {
        logic [SHORT_TS_W-1:0] short_sum;
        logic [LONG_TS_W-1:0]  long_sum;
        logic                  short_ok;
        logic                  long_ok;
    } item_t;

endpackage

// ===== design/tmwp_front.sv =====
module tmwp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  tmwp_pkg::ms_t     sample_ms,
    input  logic              pop,
    output logic              push,
    output tmwp_pkg::item_t   push_item
);

    tmwp_pkg::ms_t                       win_reg [tmwp_pkg::WIN_DEPTH];
    tmwp_pkg::ms_t                       taps [tmwp_pkg::TAP_N];
    logic [tmwp_pkg::FILL_W-1:0]         fill_reg;
    logic [tmwp_pkg::FILL_W-1:0]         fill_next;
    logic [tmwp_pkg::CREDIT_W-1:0]       credit_reg;
    logic [tmwp_pkg::CREDIT_W-1:0]       credit_next;
    logic                                s1_valid_reg;
    logic                                s1_sok_reg;
    logic                                s1_lok_reg;
    logic                                s2_valid_reg;
    logic                                s2_sok_reg;
    logic                                s2_lok_reg;
    tmwp_pkg::grp_stat_t                 s_grp_next [tmwp_pkg::NGRP];
    tmwp_pkg::grp_stat_t                 l_grp_next [tmwp_pkg::NGRP];
    tmwp_pkg::grp_stat_t                 s_grp_reg [tmwp_pkg::NGRP];
    tmwp_pkg::grp_stat_t                 l_grp_reg [tmwp_pkg::NGRP];
    tmwp_pkg::ms_t                       s_lo;
    tmwp_pkg::ms_t                       s_hi;
    tmwp_pkg::ms_t                       l_lo;
    tmwp_pkg::ms_t                       l_hi;
    logic [tmwp_pkg::FSUM_W-1:0]         s_sum;
    logic [tmwp_pkg::FSUM_W-1:0]         l_sum;
    logic [tmwp_pkg::FSUM_W-1:0]         s_trim;
    logic [tmwp_pkg::FSUM_W-1:0]         l_trim;
    logic                                accept;

    // Credits cover every word from acceptance until it leaves the queue.
    assign sample_ready = credit_reg < tmwp_pkg::CREDIT_W'(tmwp_pkg::QDEPTH);
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    assign fill_next = (fill_reg < tmwp_pkg::FILL_W'(tmwp_pkg::WIN_DEPTH)) ?
                       fill_reg + 1'b1 : fill_reg;

    // Newest sample sits at tap 0.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= sample_ms;
            for (int i = 1; i < tmwp_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    for (genvar t = 0; t < tmwp_pkg::TAP_N; t++)
    begin : g_tap
        if (t < tmwp_pkg::WIN_DEPTH)
        begin : g_live
            assign taps[t] = win_reg[t];
        end
        else
        begin : g_pad
            assign taps[t] = '0;
        end
    end

    // Per-group minimum, maximum and sum, with taps past each window neutral.
    always_comb
    begin
        for (int g = 0; g < tmwp_pkg::NGRP; g++)
        begin
            s_grp_next[g].lo  = '1;
            s_grp_next[g].hi  = '0;
            s_grp_next[g].sum = '0;
            l_grp_next[g].lo  = '1;
            l_grp_next[g].hi  = '0;
            l_grp_next[g].sum = '0;
            for (int j = 0; j < tmwp_pkg::GRP; j++)
            begin
                if (g * tmwp_pkg::GRP + j < tmwp_pkg::SHORT_LEN)
                begin
                    if (taps[g*tmwp_pkg::GRP+j] < s_grp_next[g].lo)
                    begin
                        s_grp_next[g].lo = taps[g*tmwp_pkg::GRP+j];
                    end
                    if (taps[g*tmwp_pkg::GRP+j] > s_grp_next[g].hi)
                    begin
                        s_grp_next[g].hi = taps[g*tmwp_pkg::GRP+j];
                    end
                    s_grp_next[g].sum = s_grp_next[g].sum +
                        tmwp_pkg::GRP_SUM_W'(taps[g*tmwp_pkg::GRP+j]);
                end
                if (g * tmwp_pkg::GRP + j < tmwp_pkg::LONG_LEN)
                begin
                    if (taps[g*tmwp_pkg::GRP+j] < l_grp_next[g].lo)
                    begin
                        l_grp_next[g].lo = taps[g*tmwp_pkg::GRP+j];
                    end
                    if (taps[g*tmwp_pkg::GRP+j] > l_grp_next[g].hi)
                    begin
                        l_grp_next[g].hi = taps[g*tmwp_pkg::GRP+j];
                    end
                    l_grp_next[g].sum = l_grp_next[g].sum +
                        tmwp_pkg::GRP_SUM_W'(taps[g*tmwp_pkg::GRP+j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s_grp_reg  <= s_grp_next;
            l_grp_reg  <= l_grp_next;
            s2_sok_reg <= s1_sok_reg;
            s2_lok_reg <= s1_lok_reg;
        end
        if (accept)
        begin
            s1_sok_reg <= fill_next >= tmwp_pkg::FILL_W'(tmwp_pkg::SHORT_LEN);
            s1_lok_reg <= fill_next >= tmwp_pkg::FILL_W'(tmwp_pkg::LONG_LEN);
        end
    end

    // Combine the groups and drop one minimum and one maximum.
    always_comb
    begin
        s_lo  = '1;
        s_hi  = '0;
        s_sum = '0;
        l_lo  = '1;
        l_hi  = '0;
        l_sum = '0;
        for (int g = 0; g < tmwp_pkg::NGRP; g++)
        begin
            if (s_grp_reg[g].lo < s_lo)
            begin
                s_lo = s_grp_reg[g].lo;
            end
            if (s_grp_reg[g].hi > s_hi)
            begin
                s_hi = s_grp_reg[g].hi;
            end
            if (l_grp_reg[g].lo < l_lo)
            begin
                l_lo = l_grp_reg[g].lo;
            end
            if (l_grp_reg[g].hi > l_hi)
            begin
                l_hi = l_grp_reg[g].hi;
            end
            s_sum = s_sum + tmwp_pkg::FSUM_W'(s_grp_reg[g].sum);
            l_sum = l_sum + tmwp_pkg::FSUM_W'(l_grp_reg[g].sum);
        end
        s_trim = s_sum - tmwp_pkg::FSUM_W'(s_lo) - tmwp_pkg::FSUM_W'(s_hi);
        l_trim = l_sum - tmwp_pkg::FSUM_W'(l_lo) - tmwp_pkg::FSUM_W'(l_hi);
    end

    assign push                = s2_valid_reg;
    assign push_item.short_sum = s_trim[tmwp_pkg::SHORT_TS_W-1:0];
    assign push_item.long_sum  = l_trim[tmwp_pkg::LONG_TS_W-1:0];
    assign push_item.short_ok  = s2_sok_reg;
    assign push_item.long_ok   = s2_lok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Credits can never run past the queue depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= tmwp_pkg::CREDIT_W'(tmwp_pkg::QDEPTH))
        else $error("front credit count above queue depth");

    // A word in the reduction stages always holds a credit.
    a_credit_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> credit_reg != '0)
        else $error("word in flight without a credit");

endmodule

// ===== design/tmwp_queue.sv =====
module tmwp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tmwp_pkg::item_t   push_item,
    input  logic              pop,
    output logic              has_item,
    output tmwp_pkg::item_t   head_item
);

    tmwp_pkg::item_t                 q_reg [tmwp_pkg::QDEPTH];
    logic [tmwp_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tmwp_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tmwp_pkg::CREDIT_W-1:0]   count_reg;
    logic [tmwp_pkg::CREDIT_W-1:0]   count_next;

    assign has_item  = count_reg != '0;
    assign head_item = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tmwp_pkg::QPTR_W'(tmwp_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tmwp_pkg::QPTR_W'(tmwp_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // The front only pushes when a slot is reserved for the word.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < tmwp_pkg::CREDIT_W'(tmwp_pkg::QDEPTH) || pop))
        else $error("queue pushed while full");

    // The back only pops a queue that holds a word.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> has_item)
        else $error("queue popped while empty");

endmodule

// ===== design/tmwp_back.sv =====
module tmwp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   has_item,
    input  tmwp_pkg::item_t        head_item,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [tmwp_pkg::MS_W-1:0] short_mean,
    output logic [tmwp_pkg::MS_W-1:0] long_mean,
    output logic                   short_ready,
    output logic                   long_ready
);

    logic [tmwp_pkg::SHORT_PROD_W-1:0] short_prod_reg;
    logic [tmwp_pkg::LONG_PROD_W-1:0]  long_prod_reg;
    logic                              mul_valid_reg;
    logic                              mul_sok_reg;
    logic                              mul_lok_reg;
    logic                              out_valid_reg;
    tmwp_pkg::ms_t                     short_mean_reg;
    tmwp_pkg::ms_t                     long_mean_reg;
    logic                              short_ready_reg;
    logic                              long_ready_reg;
    logic                              out_load;

    assign out_load = mul_valid_reg && (!out_valid_reg || result_ready);
    assign pop      = has_item && (!mul_valid_reg || out_load);

    // Reciprocal multiply; the quotient is a fixed slice of the product.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            short_prod_reg <= tmwp_pkg::SHORT_PROD_W'(head_item.short_sum) *
                              tmwp_pkg::SHORT_PROD_W'(tmwp_pkg::SHORT_MUL);
            long_prod_reg  <= tmwp_pkg::LONG_PROD_W'(head_item.long_sum) *
                              tmwp_pkg::LONG_PROD_W'(tmwp_pkg::LONG_MUL);
            mul_sok_reg    <= head_item.short_ok;
            mul_lok_reg    <= head_item.long_ok;
        end
        if (out_load)
        begin
            short_mean_reg  <= mul_sok_reg ?
                               short_prod_reg[tmwp_pkg::SHORT_K +: tmwp_pkg::MS_W] : '0;
            long_mean_reg   <= (mul_sok_reg && mul_lok_reg) ?
                               long_prod_reg[tmwp_pkg::LONG_K +: tmwp_pkg::MS_W] : '0;
            short_ready_reg <= mul_sok_reg;
            long_ready_reg  <= mul_lok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mul_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                mul_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign short_mean   = short_mean_reg;
    assign long_mean    = long_mean_reg;
    assign short_ready  = short_ready_reg;
    assign long_ready   = long_ready_reg;

    // A product that moves on always shows up as a valid result next cycle.
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result lost between multiply and output stages");

endmodule

// ===== design/trimmed_mean_window_pair.sv =====
// Channel  | Handshake                    | Word
// ---------+------------------------------+------------------------------------------
// sample   | sample_valid / sample_ready  | sample_ms
// result   | result_valid / result_ready  | short_mean, long_mean, short_ready,
//          |                              | long_ready
//
// One sample is taken per cycle while sample_ready is high, and each gives one result word.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears the sample count.
// A stalled result side fills the four-entry queue and then drops sample_ready.
// The group reduction stage, the queue write, the multiply stage and the output register
// set the latency; the window shift happens at the accepting edge itself.

module trimmed_mean_window_pair (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [tmwp_pkg::MS_W-1:0]     sample_ms,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tmwp_pkg::MS_W-1:0]     short_mean,
    output logic [tmwp_pkg::MS_W-1:0]     long_mean,
    output logic                          short_ready,
    output logic                          long_ready
);

    // The front part shifts each sample into the window and reduces the newest
    // short and long windows to trimmed sums in two register stages. It hands
    // out credits so that every word it starts has a queue slot waiting.
    logic              push;
    logic              pop;
    logic              has_item;
    tmwp_pkg::item_t   push_item;
    tmwp_pkg::item_t   head_item;

    tmwp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_ms    (sample_ms),
        .pop          (pop),
        .push         (push),
        .push_item    (push_item)
    );

    // The queue decouples the reduction pipeline from the divide and output side.
    tmwp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .has_item  (has_item),
        .head_item (head_item)
    );

    // The back part divides each trimmed sum by its window length minus two
    // with a reciprocal multiply, then zeroes means whose window is not full.
    tmwp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .has_item     (has_item),
        .head_item    (head_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .short_mean   (short_mean),
        .long_mean    (long_mean),
        .short_ready  (short_ready),
        .long_ready   (long_ready)
    );

endmodule

// ===== verif/tb_trimmed_mean_window_pair.sv =====
module tb_trimmed_mean_window_pair;

    // The run is bounded by a watchdog on quiet cycles. The longest quiet stretch in a
    // correct run is the deliberate result-side hold, so the limit sits well above it.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    // After the last expected word arrives, the bench keeps watching the result side
    // so that any stray result word still in the pipeline or the queue shows up.
    localparam int DRAIN_CYCLES   = 16;

    // One expected result word, field for field as the block presents it.
    typedef struct packed {
        tmwp_pkg::ms_t  short_mean;
        tmwp_pkg::ms_t  long_mean;
        logic           short_ok;
        logic           long_ok;
    } mean_pair_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          sample_valid = 1'b0;
    tmwp_pkg::ms_t sample_ms    = '0;
    logic          result_ready = 1'b0;

    logic          sample_ready;
    logic          result_valid;
    tmwp_pkg::ms_t short_mean;
    tmwp_pkg::ms_t long_mean;
    logic          short_ready;
    logic          long_ready;

    // Shadow copy of the sample window. Entries are only read once they have been
    // written, because a window is averaged only when the fill count covers it.
    tmwp_pkg::ms_t sample_hist [tmwp_pkg::WIN_DEPTH];
    int            wr_slot     = 0;
    int            seen_count  = 0;
    mean_pair_t    expected_means [$];

    int   mismatch_count = 0;
    int   sent_count     = 0;
    int   checked_count  = 0;
    int   stall_count    = 0;
    int   quiet_cycles   = 0;
    int   hold_request   = 0;
    bit   send_gaps_on   = 1'b1;
    bit   recv_gaps_on   = 1'b1;

    trimmed_mean_window_pair i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_ms    (sample_ms),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .short_mean   (short_mean),
        .long_mean    (long_mean),
        .short_ready  (short_ready),
        .long_ready   (long_ready)
    );

    always #1 clk = ~clk;

    // Trimmed mean of the newest len samples: drop one copy of the smallest and one
    // copy of the largest, then divide the rest by len minus two, rounding down.
    // Since the quotient never exceeds the largest sample, it always fits in MS_W bits.
    function automatic tmwp_pkg::ms_t trimmed_mean_of(input int len);
        logic [tmwp_pkg::MS_W+7:0] total;
        tmwp_pkg::ms_t             lo;
        tmwp_pkg::ms_t             hi;
        tmwp_pkg::ms_t             v;
        int                        pos;
        int                        i;
        total = '0;
        lo    = '1;
        hi    = '0;
        pos   = wr_slot;
        for (i = 0; i < len; i++)
        begin
            pos = (pos == 0) ? tmwp_pkg::WIN_DEPTH - 1 : pos - 1;
            v   = sample_hist[pos];
            total += v;
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
        end
        total = total - lo - hi;
        return tmwp_pkg::ms_t'(total / (tmwp_pkg::MS_W + 8)'(len - tmwp_pkg::TRIM));
    endfunction

    // Store an accepted sample in the shadow window and queue the result word it causes.
    // The long mean is also gated by the short flag; with the shipped lengths the long
    // window is never full before the short one, but the gate is kept for other lengths.
    function automatic void predict_sample(input tmwp_pkg::ms_t value);
        mean_pair_t word;
        sample_hist[wr_slot] = value;
        wr_slot = (wr_slot == tmwp_pkg::WIN_DEPTH - 1) ? 0 : wr_slot + 1;
        if (seen_count < tmwp_pkg::WIN_DEPTH)
            seen_count++;
        word.short_ok   = (seen_count >= tmwp_pkg::SHORT_LEN);
        word.long_ok    = (seen_count >= tmwp_pkg::LONG_LEN);
        word.short_mean = word.short_ok ? trimmed_mean_of(tmwp_pkg::SHORT_LEN) : '0;
        word.long_mean  = (word.short_ok && word.long_ok) ?
                          trimmed_mean_of(tmwp_pkg::LONG_LEN) : '0;
        expected_means = {expected_means, word};
    endfunction

    function automatic void check_field(input string field, input tmwp_pkg::ms_t want,
                                        input tmwp_pkg::ms_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Random sample values. A mix of classes keeps the trimming interesting: full-range
    // values exercise every input bit, while small pools and near-max values produce
    // repeated extremes and the largest possible sums.
    function automatic tmwp_pkg::ms_t random_sample();
        tmwp_pkg::ms_t value;
        case ($urandom_range(0, 5))
            0: value = tmwp_pkg::ms_t'($urandom);
            1: value = tmwp_pkg::ms_t'($urandom_range(0, 1000));
            2: value = tmwp_pkg::ms_t'(24'hFFFFFF - $urandom_range(0, 255));
            3:
            begin
                case ($urandom_range(0, 2))
                    0: value = '0;
                    1: value = '1;
                    default: value = tmwp_pkg::ms_t'(24'd12345);
                endcase
            end
            4: value = tmwp_pkg::ms_t'(60000 + $urandom_range(0, 500));
            default: value = tmwp_pkg::ms_t'($urandom);
        endcase
        return value;
    endfunction

    // Offer one sample word and hold it until the block takes it. The sender gap is drawn
    // per word; with no gap, valid simply stays high for the next word.
    task automatic send_sample(input tmwp_pkg::ms_t value);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_ms    <= value;
        @(posedge clk);
        while (!sample_ready)
        begin
            stall_count++;
            @(posedge clk);
        end
        predict_sample(value);
        sent_count++;
    endtask

    // Stop offering and wait until every expected result word has been checked.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
    endtask

    // Directed start: the first few words must report zero means and clear flags, then
    // the short window becomes ready, then the long one. The pattern covers all-zero and
    // all-max fields, repeated minima and maxima (only one copy of each is dropped),
    // and a window of all-max samples whose mean is the largest value.
    task automatic test_directed_extremes();
        tmwp_pkg::ms_t pattern [0:21];
        int            i;
        pattern = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    24'h000000, 24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF,
                    24'h000001, 24'hFFFFFE, 24'hAAAAAA, 24'h555555, 24'h00F0F0,
                    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF, 24'hFFFFFF};
        for (i = 0; i < 22; i++)
            send_sample(pattern[i]);
    endtask

    // The bulk of the run. The middle third runs with no idling on either side so the
    // block sees back-to-back words; the outer thirds put gaps on every phase.
    task automatic test_random_stream();
        int i;
        for (i = 0; i < 1200; i++)
        begin
            if (i == 400)
            begin
                send_gaps_on = 1'b0;
                recv_gaps_on = 1'b0;
            end
            else if (i == 800)
            begin
                send_gaps_on = 1'b1;
                recv_gaps_on = 1'b1;
            end
            send_sample(random_sample());
        end
    endtask

    // The result side holds off for a long stretch while the sender keeps offering words
    // with no gaps, so the internal queue fills and the block must drop sample_ready.
    task automatic test_output_backpressure();
        int i;
        send_gaps_on = 1'b0;
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 60; i++)
            send_sample(random_sample());
        send_gaps_on = 1'b1;
    endtask

    // The sender goes quiet until the block is empty, then resumes. The pipeline must
    // restart cleanly from an idle state with the window contents kept.
    task automatic test_drain_pause();
        int i;
        wait_drained();
        for (i = 0; i < 150; i++)
            send_sample(random_sample());
        wait_drained();
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        for (i = 0; i < 120; i++)
            send_sample(random_sample());
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    // Result side: draws a stall before each word if gaps are on (or serves a requested
    // long hold), then takes the next word and compares it with the oldest expectation.
    initial
    begin : result_checker
        int         stall;
        mean_pair_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = 0;
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else if (recv_gaps_on)
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            if (expected_means.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %h %h %b %b",
                         $time, short_mean, long_mean, short_ready, long_ready);
                mismatch_count++;
            end
            else
            begin
                want = expected_means.pop_front();
                check_field("short_mean", want.short_mean, short_mean);
                check_field("long_mean", want.long_mean, long_mean);
                check_field("short_ready", tmwp_pkg::ms_t'(want.short_ok),
                            tmwp_pkg::ms_t'(short_ready));
                check_field("long_ready", tmwp_pkg::ms_t'(want.long_ok),
                            tmwp_pkg::ms_t'(long_ready));
                checked_count++;
            end
        end
    end

    // Watchdog: a long run of cycles in which no word moves on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("trimmed_mean_window_pair test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_stream();
        test_output_backpressure();
        test_drain_pause();

        // Let every expected word arrive, then give any stray word time to appear.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples and %0d result words, with %0d input stall cycles.",
                 sent_count, checked_count, stall_count);
        $display("Included window fill-up, extreme values, a long result hold and drain pauses.");
        if (mismatch_count == 0)
            $display("trimmed_mean_window_pair test passed");
        else
            $display("trimmed_mean_window_pair test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tmwp_pkg.sv
design/tmwp_front.sv
design/tmwp_queue.sv
design/tmwp_back.sv
design/trimmed_mean_window_pair.sv
verif/tb_trimmed_mean_window_pair.sv
